// ----- rtl/core/sincos_minimax_approx_macros.svh -----
// ---------------------------------------------------------------------------
// sincos_minimax_approx assertion macros
// Shared property wrappers, clocked on aclk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SINCOS_MINIMAX_APPROX_MACROS_SVH
`define SINCOS_MINIMAX_APPROX_MACROS_SVH

// condition implies consequence in the same cycle
`define SCMA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// condition must never hold
`define SCMA_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

`endif

// ----- rtl/core/scma_pkg.sv -----
// ---------------------------------------------------------------------------
// scma_pkg
// Constants, coefficient tables and the rounded Q30 multiply.
// ---------------------------------------------------------------------------
package scma_pkg;

    localparam int ANGLE_W          = 32;
    localparam int RESULT_W         = 32;
    localparam int ANGLE_FRAC_BITS  = 27;
    localparam int RESULT_FRAC_BITS = 30;
    localparam int QF               = 30;
    localparam int P_W              = 34;
    localparam int N_COEF           = 6;
    localparam int RED_STAGES       = 5;
    localparam int OUT_STAGES       = 2;
    localparam int N_STAGES         = RED_STAGES + (N_COEF - 1) + OUT_STAGES;

    typedef logic signed [P_W-1:0] q30_t;
    typedef q30_t coef_arr_t [N_COEF];

    localparam logic [29:0] INV2PI_Q32 = 30'd683565276;
    localparam logic [32:0] TWOPI_Q30  = 33'd6746518852;
    localparam q30_t PI_Q30     = 34'sd3373259426;
    localparam q30_t HALFPI_Q30 = 34'sd1686629713;

    localparam coef_arr_t SIN_COEF = '{
        -34'sd26, 34'sd2956, -34'sd213040, 34'sd8947846, -34'sd178956974, 34'sd1073741824
    };
    localparam coef_arr_t COS_COEF = '{
        -34'sd280, 34'sd26586, -34'sd1491253, 34'sd44739212, -34'sd536870912, 34'sd1073741824
    };

    // product rounded half away from zero back to Q30
    function automatic q30_t mulq(input q30_t a, input q30_t b);
        logic             neg;
        logic [P_W-1:0]   ma;
        logic [P_W-1:0]   mb;
        logic [2*P_W-1:0] pr;
        logic [2*P_W-1:0] r;
        neg = a[P_W-1] ^ b[P_W-1];
        ma  = a[P_W-1] ? P_W'(-a) : P_W'(a);
        mb  = b[P_W-1] ? P_W'(-b) : P_W'(b);
        pr  = ma * mb;
        r   = (pr + ((2*P_W)'(1) << (QF - 1))) >> QF;
        return neg ? -$signed(r[P_W-1:0]) : $signed(r[P_W-1:0]);
    endfunction

endpackage

// ----- rtl/core/scma_reduce.sv -----
// ---------------------------------------------------------------------------
// scma_reduce
// Five-stage range reduction to [-pi,pi], fold to [-pi/2,pi/2] and y squared.
// ---------------------------------------------------------------------------
module scma_reduce #(
    parameter int AngleFracBits = scma_pkg::ANGLE_FRAC_BITS
) (
    input  logic                                aclk,
    input  logic [scma_pkg::RED_STAGES-1:0]     load,
    input  logic [scma_pkg::ANGLE_W-1:0]        angle,
    output scma_pkg::q30_t                      y,
    output scma_pkg::q30_t                      y2,
    output logic                                flip
);
    import scma_pkg::*;

    localparam int PROD_W = 63;
    localparam int RSH    = AngleFracBits + 32;
    localparam int QM_W   = PROD_W - RSH;
    localparam int QT_W   = QM_W + 33;
    localparam int AY_W   = ANGLE_W + QF - AngleFracBits;
    localparam int D_W    = ((AY_W > QT_W) ? AY_W : QT_W) + 1;

    logic [ANGLE_W-1:0] m0_reg, m1_reg;
    logic               neg0_reg, neg1_reg, neg2_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [QT_W-1:0]    qt_reg;
    logic [AY_W-1:0]    ay_reg;
    q30_t               y3_reg, y4_reg, y2_reg;
    logic               flip3_reg, flip4_reg;

    logic [PROD_W-1:0]     rsum;
    logic [QM_W-1:0]       qm;
    logic signed [D_W-1:0] d;
    q30_t                  yr, yf;
    logic                  fl;

    always_comb begin
        rsum = prod_reg + (PROD_W'(1) << (RSH - 1));
        qm   = QM_W'(rsum >> RSH);
        d    = $signed(D_W'(ay_reg)) - $signed(D_W'(qt_reg));
        yr   = neg2_reg ? -$signed(d[P_W-1:0]) : $signed(d[P_W-1:0]);
        fl   = 1'b0;
        yf   = yr;
        priority if (yr > HALFPI_Q30) begin
            yf = PI_Q30 - yr;
            fl = 1'b1;
        end else if (yr < -HALFPI_Q30) begin
            yf = -PI_Q30 - yr;
            fl = 1'b1;
        end else begin
            yf = yr;
        end
    end

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            neg0_reg <= angle[ANGLE_W-1];
            m0_reg   <= angle[ANGLE_W-1] ? -angle : angle;
        end
        if (load[1]) begin
            neg1_reg <= neg0_reg;
            m1_reg   <= m0_reg;
            prod_reg <= PROD_W'(m0_reg) * PROD_W'(INV2PI_Q32);
        end
        if (load[2]) begin
            neg2_reg <= neg1_reg;
            ay_reg   <= AY_W'(m1_reg) << (QF - AngleFracBits);
            qt_reg   <= QT_W'(qm) * QT_W'(TWOPI_Q30);
        end
        if (load[3]) begin
            y3_reg    <= yf;
            flip3_reg <= fl;
        end
        if (load[4]) begin
            y4_reg    <= y3_reg;
            flip4_reg <= flip3_reg;
            y2_reg    <= mulq(y3_reg, y3_reg);
        end
    end

    assign y    = y4_reg;
    assign y2   = y2_reg;
    assign flip = flip4_reg;

endmodule

// ----- rtl/core/scma_horner.sv -----
// ---------------------------------------------------------------------------
// scma_horner
// One Horner step for both polynomials: p = round(p * y2) + c.
// ---------------------------------------------------------------------------
module scma_horner #(
    parameter int Step = 1
) (
    input  logic           aclk,
    input  logic           load,
    input  scma_pkg::q30_t y_in,
    input  scma_pkg::q30_t y2_in,
    input  logic           flip_in,
    input  scma_pkg::q30_t ps_in,
    input  scma_pkg::q30_t pc_in,
    output scma_pkg::q30_t y_out,
    output scma_pkg::q30_t y2_out,
    output logic           flip_out,
    output scma_pkg::q30_t ps_out,
    output scma_pkg::q30_t pc_out
);
    import scma_pkg::*;

    q30_t y_reg, y2_reg, ps_reg, pc_reg;
    logic flip_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            y_reg    <= y_in;
            y2_reg   <= y2_in;
            flip_reg <= flip_in;
            ps_reg   <= mulq(ps_in, y2_in) + SIN_COEF[Step];
            pc_reg   <= mulq(pc_in, y2_in) + COS_COEF[Step];
        end
    end

    assign y_out    = y_reg;
    assign y2_out   = y2_reg;
    assign flip_out = flip_reg;
    assign ps_out   = ps_reg;
    assign pc_out   = pc_reg;

endmodule

// ----- rtl/core/scma_output.sv -----
// ---------------------------------------------------------------------------
// scma_output
// Final sine multiply, cosine sign, rounding to output format and saturation.
// ---------------------------------------------------------------------------
module scma_output #(
    parameter int ResultFracBits = scma_pkg::RESULT_FRAC_BITS
) (
    input  logic                                aclk,
    input  logic [scma_pkg::OUT_STAGES-1:0]     load,
    input  scma_pkg::q30_t                      y,
    input  logic                                flip,
    input  scma_pkg::q30_t                      ps,
    input  scma_pkg::q30_t                      pc,
    output logic [scma_pkg::RESULT_W-1:0]       sine,
    output logic [scma_pkg::RESULT_W-1:0]       cosine
);
    import scma_pkg::*;

    localparam int SH = QF - ResultFracBits;

    q30_t                sn_reg, cs_reg;
    logic [RESULT_W-1:0] sine_reg, cosine_reg;

    function automatic logic [RESULT_W-1:0] to_out(input q30_t v);
        logic [P_W:0] m;
        logic [P_W:0] lim;
        m   = v[P_W-1] ? (P_W+1)'(-v) : (P_W+1)'(v);
        lim = (P_W+1)'(1) << ResultFracBits;
        if (SH > 0) begin
            m = (m + ((P_W+1)'(1) << ((SH > 0) ? SH - 1 : 0))) >> SH;
        end
        if (m > lim) begin
            m = lim;
        end
        return v[P_W-1] ? RESULT_W'(-m) : RESULT_W'(m);
    endfunction

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            sn_reg <= mulq(ps, y);
            cs_reg <= flip ? -pc : pc;
        end
        if (load[1]) begin
            sine_reg   <= to_out(sn_reg);
            cosine_reg <= to_out(cs_reg);
        end
    end

    assign sine   = sine_reg;
    assign cosine = cosine_reg;

endmodule

// ----- rtl/core/sincos_minimax_approx.sv -----
// ---------------------------------------------------------------------------
// sincos_minimax_approx
// Pipelined fixed-point sine and cosine by range reduction and minimax
// polynomials.
// ---------------------------------------------------------------------------
// Usage:
//   s_ channel: one angle per transaction, signed, ANGLE_FRAC_BITS fraction
//   bits. m_ channel: sine and cosine, signed, RESULT_FRAC_BITS fraction bits,
//   saturated to +/-1.0.
//   Throughput: one transaction per cycle while m_tready keeps the output
//   moving; twelve register stages (five for reduction and squaring, five
//   Horner steps, two for output), each with its own valid bit.
//   Stall: a stage holds only while it is full and the stage after it
//   cannot take its contents, so bubbles close up and s_tready stays high
//   while the pipeline has an empty stage.
//   Reset: aresetn low clears all valid bits; no results are pending.
// ---------------------------------------------------------------------------
module sincos_minimax_approx #(
    parameter int ANGLE_FRAC_BITS  = scma_pkg::ANGLE_FRAC_BITS,
    parameter int RESULT_FRAC_BITS = scma_pkg::RESULT_FRAC_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] angle
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [31:0] sine, [63:32] cosine
);
    import scma_pkg::*;

    `include "sincos_minimax_approx_macros.svh"

    localparam int NH = N_COEF - 1;

    logic [N_STAGES-1:0] vld_reg, vld_next, load;

    q30_t y_s   [NH+1];
    q30_t y2_s  [NH+1];
    q30_t ps_s  [NH+1];
    q30_t pc_s  [NH+1];
    logic flip_s[NH+1];

    logic [RESULT_W-1:0] sine, cosine;

    always_comb begin
        load[N_STAGES-1] = !vld_reg[N_STAGES-1] || m_tready;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            load[k] = !vld_reg[k] || load[k+1];
        end
        vld_next = vld_reg;
        for (int k = 0; k < N_STAGES; k++) begin
            if (load[k]) begin
                vld_next[k] = (k == 0) ? s_tvalid : vld_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = load[0];
    assign m_tvalid = vld_reg[N_STAGES-1];

    scma_reduce #(
        .AngleFracBits(ANGLE_FRAC_BITS)
    ) u_reduce (
        .aclk  (aclk),
        .load  (load[RED_STAGES-1:0]),
        .angle (s_tdata[ANGLE_W-1:0]),
        .y     (y_s[0]),
        .y2    (y2_s[0]),
        .flip  (flip_s[0])
    );

    assign ps_s[0] = SIN_COEF[0];
    assign pc_s[0] = COS_COEF[0];

    for (genvar i = 0; i < NH; i++) begin : g_horner
        scma_horner #(
            .Step(i + 1)
        ) u_horner (
            .aclk     (aclk),
            .load     (load[RED_STAGES+i]),
            .y_in     (y_s[i]),
            .y2_in    (y2_s[i]),
            .flip_in  (flip_s[i]),
            .ps_in    (ps_s[i]),
            .pc_in    (pc_s[i]),
            .y_out    (y_s[i+1]),
            .y2_out   (y2_s[i+1]),
            .flip_out (flip_s[i+1]),
            .ps_out   (ps_s[i+1]),
            .pc_out   (pc_s[i+1])
        );
    end

    scma_output #(
        .ResultFracBits(RESULT_FRAC_BITS)
    ) u_output (
        .aclk   (aclk),
        .load   (load[N_STAGES-1:N_STAGES-OUT_STAGES]),
        .y      (y_s[NH]),
        .flip   (flip_s[NH]),
        .ps     (ps_s[NH]),
        .pc     (pc_s[NH]),
        .sine   (sine),
        .cosine (cosine)
    );

    assign m_tdata = {cosine, sine};

    `SCMA_ASSERT_IMP(a_ready_when_empty, !m_tvalid, s_tready, "input refused with output empty")
    `SCMA_ASSERT_IMP(a_full_stall, (&vld_reg) && !m_tready, !s_tready, "input taken while pipeline full")
    `SCMA_ASSERT_NEVER(a_sine_range, m_tvalid && ($signed(sine) > $signed(RESULT_W'(1) << RESULT_FRAC_BITS) || $signed(sine) < -$signed(RESULT_W'(1) << RESULT_FRAC_BITS)), "sine out of range")
    `SCMA_ASSERT_NEVER(a_cos_range, m_tvalid && ($signed(cosine) > $signed(RESULT_W'(1) << RESULT_FRAC_BITS) || $signed(cosine) < -$signed(RESULT_W'(1) << RESULT_FRAC_BITS)), "cosine out of range")

endmodule

// ----- test/sincos_minimax_approx_test.sv -----
// ----------------------------------------------------------------------------
// sincos_minimax_approx_test
// Streams angles into the sine/cosine pipeline under random source gaps and
// sink stalls, predicts each result with a bit-exact fixed-point model and
// compares sine and cosine of every output transaction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sincos_minimax_approx_test;

    localparam int AFB = scma_pkg::ANGLE_FRAC_BITS;
    localparam int RFB = scma_pkg::RESULT_FRAC_BITS;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;

    logic [63:0] sincos_expected [$];
    int          error_count = 0;
    int          items_sent = 0;
    int          results_checked = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    bit          stall_enable = 1'b1;

    sincos_minimax_approx i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic longint round_q30_mul(longint a, longint b);
        bit          neg;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] r;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? -a : a;
        mb  = (b < 0) ? -b : b;
        r   = (ma * mb + (64'd1 << 29)) >> 30;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint eval_poly(bit is_sine, longint y2);
        longint sin_c [6] = '{-26, 2956, -213040, 8947846, -178956974, 1073741824};
        longint cos_c [6] = '{-280, 26586, -1491253, 44739212, -536870912, 1073741824};
        longint p;
        p = is_sine ? sin_c[0] : cos_c[0];
        for (int i = 1; i < 6; i++) begin
            p = round_q30_mul(p, y2) + (is_sine ? sin_c[i] : cos_c[i]);
        end
        return p;
    endfunction

    function automatic logic [31:0] to_result(longint v);
        bit          neg;
        logic [63:0] m;
        int          sh;
        longint      r;
        neg = v < 0;
        m   = neg ? -v : v;
        sh  = 30 - RFB;
        if (sh > 0) begin
            m = (m + (64'd1 << (sh - 1))) >> sh;
        end
        if (m > (64'd1 << RFB)) begin
            m = 64'd1 << RFB;
        end
        r = neg ? -longint'(m) : longint'(m);
        return r[31:0];
    endfunction

    function automatic logic [63:0] predict_sincos(logic [31:0] angle);
        bit          neg;
        logic [63:0] m;
        logic [63:0] qm;
        longint      q;
        longint      y;
        longint      y2;
        longint      sn;
        longint      cs;
        bit          flip;
        neg  = angle[31];
        m    = neg ? (64'h1_0000_0000 - angle) : {32'd0, angle};
        qm   = (m * 64'd683565276 + (64'd1 << (AFB + 31))) >> (AFB + 32);
        q    = neg ? -longint'(qm) : longint'(qm);
        y    = longint'(m << (30 - AFB));
        if (neg) begin
            y = -y;
        end
        y    = y - q * 64'sd6746518852;
        flip = 1'b0;
        if (y > 64'sd1686629713) begin
            y = 64'sd3373259426 - y;
            flip = 1'b1;
        end else if (y < -64'sd1686629713) begin
            y = -64'sd3373259426 - y;
            flip = 1'b1;
        end
        y2 = round_q30_mul(y, y);
        sn = round_q30_mul(eval_poly(1'b1, y2), y);
        cs = eval_poly(1'b0, y2);
        if (flip) begin
            cs = -cs;
        end
        return {to_result(cs), to_result(sn)};
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR: %s got %0d expected %0d at %0t",
                 what, $signed(got), $signed(want), $realtime);
        error_count++;
    endtask

    // send one angle; bursts with random gaps in between
    task automatic send_angle(logic [31:0] angle);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 4)) @(posedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= angle;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sincos_expected.push_back(predict_sincos(angle));
        items_sent++;
        burst_left--;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
        end
    endtask

    task automatic finish_items();
        s_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic wait_drained();
        finish_items();
        while (sincos_expected.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    // sink stall pattern: periods of heavy, light and no back-pressure
    always @(posedge aclk) begin
        if (!stall_enable) begin
            m_tready <= 1'b1;
        end else begin
            case ((idle_cycles + results_checked / 64) % 3)
                0: m_tready <= ($urandom_range(0, 3) != 0);
                1: m_tready <= ($urandom_range(0, 1) != 0);
                default: m_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge aclk) begin
        logic [63:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (sincos_expected.size() == 0) begin
                $display("ERROR: unexpected result transaction at %0t", $realtime);
                error_count++;
            end else begin
                want = sincos_expected.pop_front();
                if (m_tdata[31:0] !== want[31:0]) begin
                    report_mismatch("sine", m_tdata[31:0], want[31:0]);
                end
                if (m_tdata[63:32] !== want[63:32]) begin
                    report_mismatch("cosine", m_tdata[63:32], want[63:32]);
                end
            end
            results_checked++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic test_field_extremes();
        logic [31:0] edge_angles [8] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
            32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0001, 32'h7FFF_FFFE, 32'h4000_0000};
        foreach (edge_angles[i]) send_angle(edge_angles[i]);
    endtask

    task automatic test_fold_boundaries();
        // angles around +/-pi/2 and +/-pi in Q4.27
        longint pts [4] = '{210828714, -210828714, 421657428, -421657428};
        foreach (pts[i]) begin
            for (int d = -1; d <= 1; d++) begin
                send_angle(32'(pts[i] + d));
            end
        end
        send_angle(32'(843314857));
        send_angle(32'(-843314857));
    endtask

    task automatic test_pause_drain();
        wait_drained();
        send_angle(32'(105414357));
    endtask

    task automatic test_random_angles(int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: send_angle($urandom);
                1: send_angle(32'($signed($urandom_range(0, 843314857 * 2)) - 843314857));
                2: send_angle(32'($urandom_range(0, 4096)) - 32'd2048);
                default: send_angle(32'(210828714 * $urandom_range(0, 40)
                                        - 210828714 * 20 + $urandom_range(0, 8) - 4));
            endcase
        end
    endtask

    task automatic test_no_stall(int n);
        wait_drained();
        stall_enable = 1'b0;
        test_random_angles(n);
        wait_drained();
        stall_enable = 1'b1;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_field_extremes();
        test_fold_boundaries();
        test_pause_drain();
        test_random_angles(1500);
        test_no_stall(250);
        wait_drained();
        $display("Covered %0d angles (field extremes, fold boundaries, random), %0d results.",
                 items_sent, results_checked);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/scma_pkg.sv
rtl/core/scma_reduce.sv
rtl/core/scma_horner.sv
rtl/core/scma_output.sv
rtl/core/sincos_minimax_approx.sv
test/sincos_minimax_approx_test.sv
